@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset cycles included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/snpd_pkg.sv @@
`default_nettype none

package snpd_pkg;

  localparam int COORD_W    = 24;
  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int ROOT_W     = DIFF_W;
  localparam int DIST_W     = 26;
  localparam int OUT_IDX_W  = 10;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_TDATA_W  = 3 * COORD_W;
  localparam int OUT_TDATA_W = ((DIST_W + OUT_IDX_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_Z = 2'd2;

  // x sits in the low bits, matching the stream packing.
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef enum logic [1:0] {
    OP_SCAN = 2'd0,
    OP_QREF = 2'd1,
    OP_PREF = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             last;
    logic [IDX_W-1:0] idx;
  } sd_tag_t;

  typedef struct packed {
    logic    valid;
    point_t  a;
    point_t  b;
    sd_tag_t tag;
  } sd_req_t;

  typedef struct packed {
    logic            valid;
    logic [SQ_W-1:0] sum;
    sd_tag_t         tag;
  } sd_rsp_t;

endpackage

`default_nettype wire

@@ design/snpd_store.sv @@
`default_nettype none

module snpd_store (
  input  wire                          clk,
  input  wire                          we,
  input  wire  [snpd_pkg::IDX_W-1:0]   waddr,
  input  wire  snpd_pkg::point_t       wdata,
  input  wire  [snpd_pkg::IDX_W-1:0]   raddr,
  output snpd_pkg::point_t             rdata
);
  import snpd_pkg::*;

  point_t mem_r [MAX_POINTS];
  point_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ design/snpd_sqdist.sv @@
`default_nettype none

module snpd_sqdist (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire snpd_pkg::sd_req_t  req,
  output snpd_pkg::sd_rsp_t       rsp
);
  import snpd_pkg::*;

  // Three stages: differences, squares, sum.
  logic                     v1_r, v2_r, v3_r;
  sd_tag_t                  tag1_r, tag2_r, tag3_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic [PROD_W-1:0]        sx_r, sy_r, sz_r;
  logic [SQ_W-1:0]          sum_r;
  logic signed [SQ_W-1:0]   px, py, pz;

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r   <= {req.a.x[COORD_W-1], req.a.x} - {req.b.x[COORD_W-1], req.b.x};
    dy_r   <= {req.a.y[COORD_W-1], req.a.y} - {req.b.y[COORD_W-1], req.b.y};
    dz_r   <= {req.a.z[COORD_W-1], req.a.z} - {req.b.z[COORD_W-1], req.b.z};
    tag1_r <= req.tag;
    sx_r   <= px[PROD_W-1:0];
    sy_r   <= py[PROD_W-1:0];
    sz_r   <= pz[PROD_W-1:0];
    tag2_r <= tag1_r;
    sum_r  <= SQ_W'(sx_r) + SQ_W'(sy_r) + SQ_W'(sz_r);
    tag3_r <= tag2_r;
  end

  assign rsp.valid = v3_r;
  assign rsp.sum   = sum_r;
  assign rsp.tag   = tag3_r;

endmodule

`default_nettype wire

@@ design/snpd_isqrt.sv @@
`default_nettype none
`include "assert_macros.svh"

module snpd_isqrt (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire  [snpd_pkg::SQ_W-1:0]    radicand,
  output logic                         done,
  output logic [snpd_pkg::ROOT_W-1:0]  root
);
  import snpd_pkg::*;

  localparam int REM_W  = ROOT_W + 2;
  localparam int STEP_W = $clog2(ROOT_W);

  logic              busy_r, done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [SQ_W-1:0]   rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W+1:0]  rem_sh, trial, diff;
  logic              ge;

  // One result bit per cycle, two radicand bits brought down each step.
  assign rem_sh = {rem_r, rad_r[SQ_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_r, 2'b01});
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= STEP_W'(ROOT_W - 1);
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign root = root_r;

  `ASSERT_CLK(a_start_when_free, clk, rst_n, start |-> !busy_r, "isqrt restarted while busy")
  `ASSERT_CLK(a_done_idle, clk, rst_n, done_r |-> !busy_r, "isqrt done while still busy")
  `ASSERT_CLK(a_done_pulse, clk, rst_n, done_r |=> !done_r, "isqrt done held past one cycle")

endmodule

`default_nettype wire

@@ design/signed_nearest_point_distance_top.sv @@
// Load, clear and unused kinds leave the block idle, so it is ready again next cycle.
// A query reads the N stored points one per cycle through the
// single read port of the point store, then runs the squared-distance pipeline, two
// reference distances and a 25-step square root. An empty-table query skips to the hand-off.
// A query also stalls for as long as an earlier result still waits at the output.
// Synchronous reset (rst_n low) also empties the table and zeroes the reference point.
`default_nettype none
`include "assert_macros.svh"

module signed_nearest_point_distance_top (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Input items.
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [snpd_pkg::IN_TDATA_W-1:0]      in_tdata,   // coord_x, coord_y, coord_z
  input  wire  [snpd_pkg::KIND_W-1:0]          in_tuser,   // kind
  // Result items.
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [snpd_pkg::OUT_TDATA_W-1:0]     out_tdata,  // signed_distance, nearest_index, pad
  output logic                                 out_tuser,  // table_empty
  // Configuration writes.
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [snpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [snpd_pkg::COORD_W-1:0]         cfg_data
);
  import snpd_pkg::*;

  // The sequencer walks a query through the scan, the drain of the distance
  // pipeline, the two reference distances, the square root and the result hand-off.
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCAN  = 8'b0000_0010,
    ST_DRAIN = 8'b0000_0100,
    ST_REFQ  = 8'b0000_1000,
    ST_REFP  = 8'b0001_0000,
    ST_WAITR = 8'b0010_0000,
    ST_SQRT  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      addr_r, addr_nxt;
  point_t                q_r, q_nxt;
  point_t                ref_r;
  logic [IDX_W-1:0]      best_r, best_nxt;
  logic [SQ_W-1:0]       best_d_r, best_d_nxt;
  logic [SQ_W-1:0]       qref_r, qref_nxt;
  logic                  neg_r, neg_nxt;
  logic                  scan_v_r;
  logic [IDX_W-1:0]      scan_idx_r;
  logic                  scan_last_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]     out_dist_r, out_dist_nxt;
  logic [OUT_IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic                  out_empty_r, out_empty_nxt;
  logic [DIST_W-1:0]     res_dist_r, res_dist_nxt;
  logic [OUT_IDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic                  res_empty_r, res_empty_nxt;

  logic                  in_acc;
  kind_t                 in_kind;
  point_t                in_point;
  logic                  last_issue;
  logic                  st_we;
  logic [IDX_W-1:0]      st_raddr;
  point_t                st_rdata;
  sd_req_t               sd_req;
  sd_rsp_t               sd_rsp;
  logic                  sq_start;
  logic                  sq_done;
  logic [ROOT_W-1:0]     sq_root;
  logic [DIST_W-1:0]     mag;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_kind   = kind_t'(in_tuser);
  assign in_point  = point_t'(in_tdata);
  assign cfg_ready = 1'b1;

  // Stored points sit in one wide memory so a single read gives all three coordinates.
  assign st_we    = in_acc && (in_kind == KIND_LOAD) && (count_r < CNT_W'(MAX_POINTS));
  assign st_raddr = (state_r == ST_SCAN) ? addr_r : best_r;

  snpd_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_point),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // The scan issues one address per cycle and stops at the last stored point.
  assign last_issue = (CNT_W'(addr_r) + 1'b1) == count_r;

  // Scan reads, the query-to-reference distance and the nearest-to-reference
  // distance all share one squared-distance pipeline, tagged so results can be sorted.
  always_comb begin
    sd_req       = '0;
    sd_req.tag.op = OP_SCAN;
    priority if (scan_v_r) begin
      sd_req.valid    = 1'b1;
      sd_req.a        = q_r;
      sd_req.b        = st_rdata;
      sd_req.tag.last = scan_last_r;
      sd_req.tag.idx  = scan_idx_r;
    end else if (state_r == ST_REFQ) begin
      sd_req.valid  = 1'b1;
      sd_req.a      = q_r;
      sd_req.b      = ref_r;
      sd_req.tag.op = OP_QREF;
    end else if (state_r == ST_REFP) begin
      sd_req.valid  = 1'b1;
      sd_req.a      = st_rdata;
      sd_req.b      = ref_r;
      sd_req.tag.op = OP_PREF;
    end
  end

  snpd_sqdist u_sqdist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sd_req),
    .rsp   (sd_rsp)
  );

  assign sq_start = sd_rsp.valid && (sd_rsp.tag.op == OP_PREF);

  snpd_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (best_d_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign mag = DIST_W'(sq_root);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    q_nxt         = q_r;
    best_nxt      = best_r;
    best_d_nxt    = best_d_r;
    qref_nxt      = qref_r;
    neg_nxt       = neg_r;
    res_dist_nxt  = res_dist_r;
    res_idx_nxt   = res_idx_r;
    res_empty_nxt = res_empty_r;
    out_valid_nxt = out_valid_r;
    out_dist_nxt  = out_dist_r;
    out_idx_nxt   = out_idx_r;
    out_empty_nxt = out_empty_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Running minimum over the scan, the first point wins on ties; reference distances set the sign.
    if (sd_rsp.valid) begin
      unique case (sd_rsp.tag.op)
        OP_SCAN: begin
          if (sd_rsp.tag.idx == '0 || sd_rsp.sum < best_d_r) begin
            best_nxt   = sd_rsp.tag.idx;
            best_d_nxt = sd_rsp.sum;
          end
        end
        OP_QREF: qref_nxt = sd_rsp.sum;
        OP_PREF: neg_nxt  = qref_r < sd_rsp.sum;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_kind)
            KIND_LOAD: begin
              if (st_we) begin
                count_nxt = count_r + 1'b1;
              end
            end
            KIND_QUERY: begin
              q_nxt = in_point;
              if (count_r == '0) begin
                res_dist_nxt  = '0;
                res_idx_nxt   = '0;
                res_empty_nxt = 1'b1;
                state_nxt     = ST_FIN;
              end else begin
                addr_nxt  = '0;
                state_nxt = ST_SCAN;
              end
            end
            KIND_CLEAR: count_nxt = '0;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        addr_nxt = addr_r + 1'b1;
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sd_rsp.valid && sd_rsp.tag.op == OP_SCAN && sd_rsp.tag.last) begin
          state_nxt = ST_REFQ;
        end
      end
      ST_REFQ: state_nxt = ST_REFP;
      ST_REFP: state_nxt = ST_WAITR;
      ST_WAITR: begin
        if (sq_start) begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          res_dist_nxt  = neg_r ? (DIST_W'(0) - mag) : mag;
          res_idx_nxt   = OUT_IDX_W'(best_r);
          res_empty_nxt = 1'b0;
          state_nxt     = ST_FIN;
        end
      end
      ST_FIN: begin
        // The result waits here only while an earlier one still sits in the output.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = res_dist_r;
          out_idx_nxt   = res_idx_r;
          out_empty_nxt = res_empty_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      scan_v_r    <= 1'b0;
      ref_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      scan_v_r    <= (state_r == ST_SCAN);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_REF_X: ref_r.x <= cfg_data;
          CFG_REF_Y: ref_r.y <= cfg_data;
          CFG_REF_Z: ref_r.z <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    q_r         <= q_nxt;
    best_r      <= best_nxt;
    best_d_r    <= best_d_nxt;
    qref_r      <= qref_nxt;
    neg_r       <= neg_nxt;
    scan_idx_r  <= addr_r;
    scan_last_r <= last_issue;
    res_dist_r  <= res_dist_nxt;
    res_idx_r   <= res_idx_nxt;
    res_empty_r <= res_empty_nxt;
    out_dist_r  <= out_dist_nxt;
    out_idx_r   <= out_idx_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_idx_r, out_dist_r});
  assign out_tuser  = out_empty_r;

  `ASSERT_CLK(a_count_bound, clk, rst_n, count_r <= CNT_W'(MAX_POINTS), "point count over capacity")
  `ASSERT_CLK(a_load_counts, clk, rst_n, st_we |=> count_r == $past(count_r) + 1'b1, "load not counted")
  `ASSERT_CLK(a_empty_zero, clk, rst_n, (out_tvalid && out_tuser) |-> out_tdata == '0, "empty result carries data")

endmodule

`default_nettype wire

@@ tb/sv/signed_nearest_point_distance_top_test.sv @@
`timescale 1ns / 100ps

import snpd_pkg::*;

// One expected query answer, laid out field by field as the block reports it.
typedef struct packed {
  logic [DIST_W-1:0]    signed_dist;
  logic [OUT_IDX_W-1:0] idx;
  logic                 empty;
} distance_result_t;

// Tracks the point table and the reference point on its own. Every query item
// queues the answer the block should give, and every result pops the oldest one.
class distance_scoreboard;
  point_t           stored_points [MAX_POINTS];
  int unsigned      stored_count;
  point_t           ref_point;
  distance_result_t pending_distances [$];
  int unsigned      mismatches;
  int unsigned      results_seen;

  function new();
    stored_count = 0;
    ref_point    = '0;
    mismatches   = 0;
    results_seen = 0;
  endfunction

  function int unsigned pending();
    return pending_distances.size();
  endfunction

  // Writes to the spare register index change nothing.
  function void write_ref(logic [CFG_IDX_W-1:0] index, logic [COORD_W-1:0] value);
    case (index)
      CFG_REF_X: ref_point.x = value;
      CFG_REF_Y: ref_point.y = value;
      CFG_REF_Z: ref_point.z = value;
      default: ;
    endcase
  endfunction

  // Exact squared Euclidean distance between two points.
  function longint unsigned square_span(point_t a, point_t b);
    longint dx, dy, dz;
    dx = longint'($signed(a.x)) - longint'($signed(b.x));
    dy = longint'($signed(a.y)) - longint'($signed(b.y));
    dz = longint'($signed(a.z)) - longint'($signed(b.z));
    return $unsigned(dx * dx + dy * dy + dz * dz);
  endfunction

  // Largest root whose square does not exceed n, built one bit at a time.
  function longint unsigned floor_root(longint unsigned n);
    longint unsigned root, trial;
    root = 0;
    for (int b = ROOT_W; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function distance_result_t nearest_distance(point_t q);
    distance_result_t r;
    longint unsigned  best_sq, sq, root;
    int unsigned      best;
    r = '0;
    if (stored_count == 0) begin
      r.empty = 1'b1;
      return r;
    end
    best    = 0;
    best_sq = square_span(q, stored_points[0]);
    // A strict compare keeps the earliest point when distances tie.
    for (int unsigned i = 1; i < stored_count; i++) begin
      sq = square_span(q, stored_points[i]);
      if (sq < best_sq) begin
        best_sq = sq;
        best    = i;
      end
    end
    root          = floor_root(best_sq);
    r.signed_dist = root[DIST_W-1:0];
    // Negative only when the query is strictly nearer the reference point.
    if (square_span(q, ref_point) < square_span(stored_points[best], ref_point)) begin
      r.signed_dist = ~r.signed_dist + 1'b1;
    end
    r.idx = best[OUT_IDX_W-1:0];
    return r;
  endfunction

  function void note_input(logic [KIND_W-1:0] kind, point_t p);
    case (kind)
      KIND_LOAD: begin
        if (stored_count < MAX_POINTS) begin
          stored_points[stored_count] = p;
          stored_count++;
        end
      end
      KIND_CLEAR: stored_count = 0;
      KIND_QUERY: pending_distances = {pending_distances, nearest_distance(p)};
      default: ;
    endcase
  endfunction

  task report_mismatch(string what);
    $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
    mismatches++;
  endtask

  task check_result(logic [OUT_TDATA_W-1:0] data, logic empty_flag);
    distance_result_t      want;
    logic [DIST_W-1:0]    got_dist;
    logic [OUT_IDX_W-1:0] got_idx;
    results_seen++;
    got_dist = data[DIST_W-1:0];
    got_idx  = data[DIST_W +: OUT_IDX_W];
    if (pending_distances.size() == 0) begin
      report_mismatch("result arrived with no query waiting");
      return;
    end
    want = pending_distances.pop_front();
    if (got_dist !== want.signed_dist) begin
      report_mismatch($sformatf("signed_distance %0d, expected %0d",
                                $signed(got_dist), $signed(want.signed_dist)));
    end
    if (got_idx !== want.idx) begin
      report_mismatch($sformatf("nearest_index %0d, expected %0d", got_idx, want.idx));
    end
    if (empty_flag !== want.empty) begin
      report_mismatch($sformatf("table_empty %0b, expected %0b", empty_flag, want.empty));
    end
  endtask
endclass

module signed_nearest_point_distance_top_test;

  // The slowest honest run, every item a query on the largest table under
  // heavy back-pressure, stays several times below this.
  localparam int LIMIT_CYCLES  = 1_000_000;
  // Length of the one long receiver hold-off that backs up the block.
  localparam int HOLD_CYCLES   = 2000;
  // Quiet time after the last result, well past any trailing load or clear.
  localparam int SETTLE_CYCLES = 100;
  // Size of the larger table built in the third phase.
  localparam int FILL_POINTS   = 160;
  localparam int COORD_MAX     = 8388607;
  localparam int COORD_MIN     = -8388608;

  // The spare kind code and the spare register index, both ignored by the block.
  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  wire                    in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]      in_tuser   = '0;
  wire                    out_tvalid;
  logic                   out_tready = 1'b0;
  wire  [OUT_TDATA_W-1:0] out_tdata;
  wire                    out_tuser;
  logic                   cfg_valid  = 1'b0;
  wire                    cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [COORD_W-1:0]     cfg_data   = '0;

  // Percent chance per cycle that the sender or the receiver sits idle.
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_go       = 1'b0;
  logic        hold_results  = 1'b0;
  int unsigned cycle_count   = 0;
  // The reference point as last written, used to aim items near it.
  point_t      cur_ref       = '0;

  distance_scoreboard sb;

  signed_nearest_point_distance_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver drops tready at random, and holds it low while the long
  // hold-off runs. Every change happens at a rising edge.
  always @(posedge clk) begin
    if (!rst_n || hold_results) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Results are checked at the edge where they are taken, so the values seen
  // are the ones that held during the cycle before it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser);
    end
  end

  // Once asked for, the receiver stops taking results for a long stretch. The
  // sender keeps offering items, so a query waits on its result and the
  // block has to stop taking items.
  initial begin : result_backpressure
    while (!hold_go) @(posedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic point_t make_point(int x, int y, int z);
    point_t p;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    p.z = COORD_W'(z);
    return p;
  endfunction

  function automatic point_t random_point();
    point_t p;
    p.x = COORD_W'($urandom);
    p.y = COORD_W'($urandom);
    p.z = COORD_W'($urandom);
    return p;
  endfunction

  // Mixes the full range with values clustered around the reference point, so
  // that queries often land nearer to it than the stored points do and the
  // sign flips. The tight cluster makes ties in distance fairly common.
  function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] center);
    case ($urandom_range(9))
      0, 1, 2, 3: return COORD_W'($urandom);
      4, 5, 6:    return center + COORD_W'($urandom_range(16383)) - COORD_W'(8192);
      7:          return center + COORD_W'($urandom_range(6)) - COORD_W'(3);
      8:          return ($urandom_range(1) != 0) ? COORD_W'(COORD_MAX) : COORD_W'(COORD_MIN);
      default:    return COORD_W'($urandom_range(8191)) - COORD_W'(4096);
    endcase
  endfunction

  function automatic point_t pick_point();
    point_t p;
    p.x = pick_coord(cur_ref.x);
    p.y = pick_coord(cur_ref.y);
    p.z = pick_coord(cur_ref.z);
    return p;
  endfunction

  // Offers one item and waits until the block takes it. tvalid stays high
  // into the next item unless the sender decides to idle for a while.
  task automatic send_item(logic [KIND_W-1:0] kind, point_t p);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= p;
    do @(posedge clk); while (!in_tready);
    sb.note_input(kind, p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Writes the reference point, with a write to the spare index in between
  // that must leave it alone. Only called while the block is idle.
  task automatic configure(point_t r, logic [COORD_W-1:0] junk);
    logic [CFG_IDX_W-1:0] idx_list [4];
    logic [COORD_W-1:0]   val_list [4];
    idx_list = '{CFG_REF_X, CFG_UNUSED, CFG_REF_Y, CFG_REF_Z};
    val_list = '{r.x, junk, r.y, r.z};
    cfg_valid <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_index <= idx_list[k];
      cfg_data  <= val_list[k];
      do @(posedge clk); while (!cfg_ready);
      sb.write_ref(idx_list[k], val_list[k]);
    end
    cfg_valid <= 1'b0;
    cur_ref = r;
  endtask

  // Stops offering items, waits for every expected result, then lets the
  // block finish any trailing load or clear.
  task automatic settle_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed runs: clear the table, load a handful of points with
  // a few queries mixed in, then query it. The rest is noise: the spare kind,
  // queries on an empty table, and items of any kind with random data.
  // Large tables show up now and then only, to keep queries short.
  task automatic run_mixed(int quota);
    int                sent;
    int                n;
    logic [KIND_W-1:0] k_any;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(99) < 85) begin
          send_item(KIND_CLEAR, random_point());
          sent++;
        end
        n = ($urandom_range(11) == 0) ? $urandom_range(160, 60) : $urandom_range(20, 1);
        repeat (n) begin
          send_item(KIND_LOAD, pick_point());
          sent++;
          if ($urandom_range(99) < 12) begin
            send_item(KIND_QUERY, pick_point());
            sent++;
          end
        end
        repeat ($urandom_range(3, 1)) begin
          send_item(KIND_QUERY, pick_point());
          sent++;
        end
      end else begin
        case ($urandom_range(3))
          0: begin
            send_item(KIND_UNUSED, random_point());
            sent++;
          end
          1: begin
            send_item(KIND_CLEAR, random_point());
            send_item(KIND_QUERY, pick_point());
            sent += 2;
          end
          2: begin
            k_any = KIND_W'($urandom);
            send_item(k_any, random_point());
            sent++;
          end
          default: begin
            send_item(KIND_QUERY, random_point());
            sent++;
          end
        endcase
      end
    end
  endtask

  initial begin : stimulus
    point_t first_pt, last_pt, spare_pt;
    sb = new();
    send_idle_pct = 35;
    recv_idle_pct <= 68;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items, with the reference point still at its reset value of
    // the origin. A query right after reset finds the table empty.
    send_item(KIND_QUERY, make_point(COORD_MAX, COORD_MIN, 0));
    send_item(KIND_LOAD, make_point(COORD_MAX, COORD_MAX, COORD_MAX));
    send_item(KIND_LOAD, make_point(COORD_MIN, COORD_MIN, COORD_MIN));
    // On a stored point: zero distance, and equal reference distances keep
    // the sign positive.
    send_item(KIND_QUERY, make_point(COORD_MIN, COORD_MIN, COORD_MIN));
    // A third corner: every coordinate difference to the stored points is zero or full range.
    send_item(KIND_QUERY, make_point(COORD_MAX, COORD_MIN, COORD_MAX));
    // The origin is the reference point itself, so the answer is negative.
    send_item(KIND_QUERY, make_point(0, 0, 0));
    // The spare kind must neither store a point nor answer.
    send_item(KIND_UNUSED, make_point(COORD_MIN, COORD_MAX, -1));
    send_item(KIND_QUERY, make_point(-1, -1, -1));
    send_item(KIND_CLEAR, make_point(0, 0, 0));
    send_item(KIND_QUERY, make_point(4096, 0, 0));
    send_item(KIND_LOAD, make_point(4096, 0, 0));
    send_item(KIND_LOAD, make_point(-4096, 0, 0));
    send_item(KIND_LOAD, make_point(4096, 0, 0));
    // Both first points are equally near: the first one wins, and the sign
    // is negative since the query sits on the reference point.
    send_item(KIND_QUERY, make_point(0, 0, 0));
    // Tied in distance again, and tied in distance to the reference point.
    send_item(KIND_QUERY, make_point(0, 4096, 0));
    // The duplicate point must lose to the earlier copy.
    send_item(KIND_QUERY, make_point(4096, 0, 0));
    send_item(KIND_QUERY, make_point(-8192, 0, 0));
    // Small odd offsets check that the square root rounds down.
    send_item(KIND_QUERY, make_point(1, 1, 1));
    send_item(KIND_QUERY, make_point(3, -2, 7));
    settle_results();

    // First random phase: a reference point close to the origin.
    configure(make_point($urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
                         $urandom_range(8191) - 4096), COORD_W'($urandom));
    run_mixed(125);
    settle_results();

    // Second phase: reference point at the top corner, idling swapped, and
    // the long receiver hold-off starting right away.
    configure(make_point(COORD_MAX, COORD_MAX, COORD_MAX), COORD_W'($urandom));
    send_idle_pct = 68;
    recv_idle_pct <= 35;
    hold_go       <= 1'b1;
    run_mixed(125);
    settle_results();

    // Third phase, no idling: reference point at the bottom corner, and a
    // larger table of random points.
    configure(make_point(COORD_MIN, COORD_MIN, COORD_MIN), COORD_W'($urandom));
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    send_item(KIND_CLEAR, random_point());
    for (int k = 0; k < FILL_POINTS; k++) begin
      last_pt = random_point();
      if (k == 0) first_pt = last_pt;
      send_item(KIND_LOAD, last_pt);
    end
    // Three copies of one point: the first copy must win.
    spare_pt = random_point();
    repeat (3) send_item(KIND_LOAD, spare_pt);
    // The last and the first random points answer with their own indexes.
    send_item(KIND_QUERY, last_pt);
    send_item(KIND_QUERY, first_pt);
    send_item(KIND_QUERY, spare_pt);
    send_item(KIND_QUERY, make_point(COORD_MIN, COORD_MAX, COORD_MIN));
    // After a clear, loads are taken again from index zero.
    send_item(KIND_CLEAR, random_point());
    send_item(KIND_LOAD, spare_pt);
    send_item(KIND_QUERY, spare_pt);
    settle_results();

    configure(random_point(), COORD_W'($urandom));
    run_mixed(125);
    settle_results();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
